### design/tgr_pkg.sv
package tgr_pkg;

  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_TOUCHUP = 2'd2;

  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_THRESH     = 3'd1;
  localparam logic [2:0] REG_THRESH_ALT = 3'd2;
  localparam logic [2:0] REG_SWITCH     = 3'd3;
  localparam logic [2:0] REG_RETURN     = 3'd4;
  localparam logic [2:0] REG_LIMIT      = 3'd5;
  localparam logic [2:0] REG_MOVE       = 3'd6;
  localparam logic [2:0] REG_LIFT       = 3'd7;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_GHOST    = 2'd1;
  localparam logic [1:0] MODE_RELEASED = 2'd2;

  localparam int RatioScale = 100;
  localparam int RatioW     = 15;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  finger;
    logic        touched;
    logic        reported;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  width_x;
    logic [7:0]  width_y;
    logic [7:0]  pressure;
  } cmd_t;

  typedef struct packed {
    logic [3:0] out_finger;
    logic       suppress;
    logic       send_cancel;
    logic [1:0] ghost_mode;
    logic [7:0] ghost_count;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        count;
    logic [RatioW-1:0] thresh;
    logic [15:0]       lift_time;
    logic [11:0]       down_x;
    logic [11:0]       down_y;
    logic              prev_touch;
    logic              reported;
  } entry_t;

endpackage

### design/tgr_div.sv
module tgr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tgr_pkg::RatioW-1:0] dividend_i,
  input  logic [7:0]                divisor_i,
  output logic                      done_o,
  output logic [tgr_pkg::RatioW-1:0] quot_o
);
  import tgr_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [3:0]        cnt_q;
  logic [RatioW-1:0] quot_q;
  logic [7:0]        rem_q;
  logic [7:0]        div_q;
  logic [8:0]        trial;
  logic              fits;

  assign trial = {rem_q, quot_q[RatioW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'(RatioW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[RatioW-2:0], fits};
      rem_q  <= fits ? 8'(trial - {1'b0, div_q}) : trial[7:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/touch_water_ghost_rejector_top.sv
// frame word: one result per word once the 15-step serial ratio divider finishes
// tick word: walks every finger's slot through the read and evaluate states, results streamed
// force touch-up, disabled ticks and ignored words are taken without leaving idle
// results are strobed for one cycle each; the receiver cannot stall
// async active-low reset restores register defaults and marks all slots as zero
module touch_water_ghost_rejector_top #(
  parameter int FINGERS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tgr_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  output tgr_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  import tgr_pkg::*;

  localparam int IdxW = (FINGERS > 1) ? $clog2(FINGERS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRAME = 3'd1;
  localparam logic [2:0] S_TRD   = 3'd2;
  localparam logic [2:0] S_TEV   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic              en_q;
  logic [RatioW-1:0] thr_q, alt_q, sw_q, ret_q;
  logic [7:0]        lim_q;
  logic [11:0]       mcd_q;
  logic [15:0]       lct_q;
  logic [15:0]       tick_q;

  logic [2:0]      state_q, state_d;
  cmd_t            cmd_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            pend_v_q, pend_v_d;
  res_t            pend_q, pend_d;
  logic            res_valid_d;
  res_t            res_q, res_d;

  entry_t          mem [FINGERS];
  entry_t          rd_raw_q;
  logic [FINGERS-1:0] vld_q, mcv_q;
  logic            rd_v_q, rd_mc_q;
  logic [IdxW-1:0] ra;
  logic            re;
  logic            we;
  logic [IdxW-1:0] wa;
  entry_t          wd;
  entry_t          e;

  logic              accept;
  logic              frame_ok;
  logic              div_start, div_done;
  logic [RatioW-1:0] ratio;
  logic [RatioW-1:0] dividend;
  logic [7:0]        divisor;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign frame_ok    = {1'b0, cmd_i.finger} < 5'(FINGERS);

  assign dividend  = RatioW'(cmd_i.pressure) * RatioW'(RatioScale);
  assign divisor   = (cmd_i.width_x >= cmd_i.width_y) ?
                     ((cmd_i.width_x == 8'd0) ? 8'd1 : cmd_i.width_x) :
                     cmd_i.width_y;
  assign div_start = accept && cmd_i.op == OP_FRAME && frame_ok;

  tgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (ratio)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b1;
      thr_q <= RatioW'(100);
      alt_q <= RatioW'(150);
      sw_q  <= RatioW'(50);
      ret_q <= RatioW'(200);
      lim_q <= 8'd30;
      mcd_q <= 12'd100;
      lct_q <= 16'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:     en_q  <= cfg_data_i[0];
        REG_THRESH:     thr_q <= cfg_data_i[RatioW-1:0];
        REG_THRESH_ALT: alt_q <= cfg_data_i[RatioW-1:0];
        REG_SWITCH:     sw_q  <= cfg_data_i[RatioW-1:0];
        REG_RETURN:     ret_q <= cfg_data_i[RatioW-1:0];
        REG_LIMIT:      lim_q <= cfg_data_i[7:0];
        REG_MOVE:       mcd_q <= cfg_data_i[11:0];
        REG_LIFT:       lct_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_raw_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      mcv_q   <= '0;
      rd_v_q  <= 1'b0;
      rd_mc_q <= 1'b0;
    end else begin
      if (re) begin
        rd_v_q  <= vld_q[ra];
        rd_mc_q <= mcv_q[ra];
      end
      if (accept && cmd_i.op == OP_TOUCHUP) begin
        mcv_q <= '0;
      end else if (we) begin
        vld_q[wa] <= 1'b1;
        mcv_q[wa] <= 1'b1;
      end
    end
  end

  always_comb begin
    e = rd_v_q ? rd_raw_q : '0;
    if (!rd_mc_q) begin
      e.mode  = MODE_NORMAL;
      e.count = '0;
    end
  end

  assign re = (state_q == S_IDLE) ? div_start : (state_q == S_TRD);
  assign ra = (state_q == S_IDLE) ? cmd_i.finger[IdxW-1:0] : idx_q;

  // frame update
  logic [11:0] dxa, dya;
  logic        moved;
  logic [15:0] gap;
  entry_t      fe;
  logic        f_sup, f_can;

  assign dxa   = (e.down_x >= cmd_q.pos_x) ? e.down_x - cmd_q.pos_x : cmd_q.pos_x - e.down_x;
  assign dya   = (e.down_y >= cmd_q.pos_y) ? e.down_y - cmd_q.pos_y : cmd_q.pos_y - e.down_y;
  assign moved = (dxa >= mcd_q) || (dya >= mcd_q);
  assign gap   = tick_q - e.lift_time;

  always_comb begin
    fe    = e;
    f_sup = 1'b0;
    f_can = 1'b0;
    if (en_q) begin
      if (e.mode == MODE_NORMAL) begin
        if (cmd_q.touched) begin
          if ((!e.prev_touch && (e.count == '0 || gap > lct_q)) ||
              (e.prev_touch && moved)) begin
            fe.count  = '0;
            fe.down_x = cmd_q.pos_x;
            fe.down_y = cmd_q.pos_y;
            fe.thresh = thr_q;
          end
          if (ratio <= sw_q) begin
            fe.thresh = alt_q;
          end
          if (ratio <= fe.thresh) begin
            if (fe.count != 8'hFF) begin
              fe.count = fe.count + 8'd1;
            end
            if (fe.count >= lim_q) begin
              fe.mode = MODE_GHOST;
              f_sup   = 1'b1;
              f_can   = cmd_q.reported;
            end
          end
        end else begin
          fe.lift_time = tick_q;
        end
      end else if (!cmd_q.touched) begin
        fe.mode  = MODE_NORMAL;
        fe.count = '0;
      end else if (e.mode == MODE_GHOST) begin
        if (ratio < ret_q && !moved) begin
          f_sup = 1'b1;
        end else begin
          fe.mode  = MODE_RELEASED;
          fe.count = '0;
        end
      end
    end
    fe.prev_touch = cmd_q.touched;
    fe.reported   = cmd_q.reported;
  end

  // tick update
  entry_t te;
  logic   t_hit, t_ghost;

  always_comb begin
    te      = e;
    t_hit   = e.prev_touch && e.mode == MODE_NORMAL && e.count != '0 && e.count < lim_q;
    t_ghost = t_hit && ({1'b0, e.count} + 9'd1 >= {1'b0, lim_q});
    if (t_ghost) begin
      te.count = lim_q;
      te.mode  = MODE_GHOST;
    end else if (t_hit) begin
      te.count = e.count + 8'd1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    wa          = idx_q;
    wd          = te;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.op == OP_FRAME && frame_ok) begin
            state_d = S_FRAME;
          end else if (cmd_i.op == OP_TICK && en_q) begin
            state_d  = S_TRD;
            idx_d    = '0;
            pend_v_d = 1'b0;
          end
        end
      end
      S_FRAME: begin
        if (div_done) begin
          we          = 1'b1;
          wa          = cmd_q.finger[IdxW-1:0];
          wd          = fe;
          res_valid_d = 1'b1;
          res_d       = '{out_finger: cmd_q.finger, suppress: f_sup, send_cancel: f_can,
                          ghost_mode: fe.mode, ghost_count: fe.count, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_TRD: begin
        state_d = S_TEV;
      end
      S_TEV: begin
        we = t_hit;
        if (t_ghost) begin
          res_valid_d = pend_v_q;
          res_d       = pend_q;
          pend_v_d    = 1'b1;
          pend_d      = '{out_finger: 4'(idx_q), suppress: 1'b0, send_cancel: e.reported,
                          ghost_mode: te.mode, ghost_count: te.count, last: 1'b0};
        end
        if (idx_q == IdxW'(FINGERS - 1)) begin
          state_d = S_FLUSH;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_TRD;
        end
      end
      S_FLUSH: begin
        res_valid_d = pend_v_q;
        res_d       = pend_q;
        res_d.last  = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      res_valid_o <= 1'b0;
      tick_q      <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_v_q    <= pend_v_d;
      res_valid_o <= res_valid_d;
      if (accept && cmd_i.op == OP_TICK) begin
        tick_q <= tick_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

  a_finger_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ({1'b0, res_o.out_finger} < 5'(FINGERS)))
    else $error("result finger out of range");

  a_div_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_FRAME)
    else $error("divider finished outside a frame");

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.op == OP_TICK) |=> tick_q == $past(tick_q) + 16'd1)
    else $error("tick counter did not advance");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && pend_v_q) |=> (res_valid_o && res_o.last))
    else $error("tick walk ended without a last result");

endmodule

### sim/touch_water_ghost_rejector_top_tb.sv
`timescale 1ns / 1ps

module touch_water_ghost_rejector_top_tb;
  import tgr_pkg::*;

  localparam int FINGERS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  touch_water_ghost_rejector_top #(.FINGERS(FINGERS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // filter settings as the block should hold them
  logic        flt_enable;
  logic [14:0] flt_thresh, flt_thresh_alt, flt_switch, flt_return;
  logic [7:0]  flt_limit;
  logic [11:0] flt_move;
  logic [15:0] flt_lift;

  // per-finger state
  logic [1:0]  slot_mode [FINGERS];
  logic [7:0]  slot_count [FINGERS];
  logic [14:0] slot_thresh [FINGERS];
  logic [15:0] slot_lift [FINGERS];
  logic [11:0] slot_dx [FINGERS];
  logic [11:0] slot_dy [FINGERS];
  logic        slot_touch [FINGERS];
  logic        slot_rep [FINGERS];
  logic [15:0] tick_now;

  cmd_t pending_words[$];
  res_t expected_words[$];
  int   idle_pct;
  logic took_word;
  int   cycles, errors, words_in, words_out, ghosts_seen;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic logic far_from_down(int f, logic [11:0] x, logic [11:0] y);
    int ddx, ddy;
    ddx = (slot_dx[f] >= x) ? slot_dx[f] - x : x - slot_dx[f];
    ddy = (slot_dy[f] >= y) ? slot_dy[f] - y : y - slot_dy[f];
    return (ddx >= flt_move) || (ddy >= flt_move);
  endfunction

  function automatic void restart_slot(int f, logic [11:0] x, logic [11:0] y);
    slot_count[f] = '0;
    slot_dx[f] = x;
    slot_dy[f] = y;
    slot_thresh[f] = flt_thresh;
  endfunction

  function automatic void reset_filter();
    flt_enable = 1'b1;
    flt_thresh = 15'd100;
    flt_thresh_alt = 15'd150;
    flt_switch = 15'd50;
    flt_return = 15'd200;
    flt_limit = 8'd30;
    flt_move = 12'd100;
    flt_lift = 16'd30;
    tick_now = '0;
    for (int f = 0; f < FINGERS; f++) begin
      slot_mode[f] = MODE_NORMAL; slot_count[f] = '0; slot_thresh[f] = '0;
      slot_lift[f] = '0; slot_dx[f] = '0; slot_dy[f] = '0;
      slot_touch[f] = 1'b0; slot_rep[f] = 1'b0;
    end
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [15:0] d);
    case (idx)
      REG_ENABLE:     flt_enable = d[0];
      REG_THRESH:     flt_thresh = d[14:0];
      REG_THRESH_ALT: flt_thresh_alt = d[14:0];
      REG_SWITCH:     flt_switch = d[14:0];
      REG_RETURN:     flt_return = d[14:0];
      REG_LIMIT:      flt_limit = d[7:0];
      REG_MOVE:       flt_move = d[11:0];
      default:        flt_lift = d;
    endcase
  endfunction

  function automatic void filter_word(cmd_t c);
    int f, w, ratio;
    logic sup, cancel;
    logic [15:0] gap;
    res_t r;
    res_t burst[$];
    f = c.finger;
    case (c.op)
      OP_FRAME: if (f < FINGERS) begin
        sup = 1'b0;
        cancel = 1'b0;
        w = (c.width_x >= c.width_y) ? c.width_x : c.width_y;
        if (w == 0) w = 1;
        ratio = (c.pressure * 100) / w;
        if (flt_enable) begin
          if (slot_mode[f] == MODE_NORMAL) begin
            if (c.touched) begin
              if (!slot_touch[f]) begin
                gap = tick_now - slot_lift[f];
                if (slot_count[f] == 0 || gap > flt_lift) restart_slot(f, c.pos_x, c.pos_y);
              end else if (far_from_down(f, c.pos_x, c.pos_y)) begin
                restart_slot(f, c.pos_x, c.pos_y);
              end
              if (ratio <= flt_switch) slot_thresh[f] = flt_thresh_alt;
              if (ratio <= slot_thresh[f]) begin
                if (slot_count[f] < 255) slot_count[f]++;
                if (slot_count[f] >= flt_limit) begin
                  slot_mode[f] = MODE_GHOST;
                  sup = 1'b1;
                  cancel = c.reported;
                  ghosts_seen++;
                end
              end
            end else begin
              slot_lift[f] = tick_now;
            end
          end else if (!c.touched) begin
            slot_mode[f] = MODE_NORMAL;
            slot_count[f] = '0;
          end else if (slot_mode[f] == MODE_GHOST) begin
            if (ratio < flt_return && !far_from_down(f, c.pos_x, c.pos_y)) begin
              sup = 1'b1;
            end else begin
              slot_mode[f] = MODE_RELEASED;
              slot_count[f] = '0;
            end
          end
        end
        slot_touch[f] = c.touched;
        slot_rep[f] = c.reported;
        r = '{out_finger: f[3:0], suppress: sup, send_cancel: cancel,
              ghost_mode: slot_mode[f], ghost_count: slot_count[f], last: 1'b1};
        expected_words.push_back(r);
      end
      OP_TICK: begin
        tick_now++;
        if (flt_enable) begin
          for (int i = 0; i < FINGERS; i++) begin
            if (slot_touch[i] && slot_mode[i] == MODE_NORMAL && slot_count[i] > 0 &&
                slot_count[i] < flt_limit) begin
              if (slot_count[i] + 1 >= flt_limit) begin
                slot_count[i] = flt_limit;
                slot_mode[i] = MODE_GHOST;
                ghosts_seen++;
                r = '{out_finger: i[3:0], suppress: 1'b0, send_cancel: slot_rep[i],
                      ghost_mode: MODE_GHOST, ghost_count: flt_limit, last: 1'b0};
                burst.push_back(r);
              end else begin
                slot_count[i]++;
              end
            end
          end
          if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
          foreach (burst[k]) expected_words.push_back(burst[k]);
        end
      end
      OP_TOUCHUP: begin
        for (int i = 0; i < FINGERS; i++) begin
          slot_mode[i] = MODE_NORMAL;
          slot_count[i] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, res_t got, res_t want);
    errors++;
    $display("[%0t] mismatch %s: got %p want %p", $realtime, what, got, want);
  endtask

  // acceptance and result checking
  always @(posedge clk_i) begin
    res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("touch_water_ghost_rejector_top regression: fail");
      $finish;
    end else if (rst_ni) begin
      took_word <= start && !busy;
      if (start && !busy) begin
        filter_word(cmd_i);
        void'(pending_words.pop_front());
        words_in++;
      end
      if (res_valid_o) begin
        words_out++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", res_o, '0);
        end else begin
          want = expected_words.pop_front();
          if (res_o.out_finger !== want.out_finger) report_mismatch("finger", res_o, want);
          if (res_o.suppress !== want.suppress) report_mismatch("suppress", res_o, want);
          if (res_o.send_cancel !== want.send_cancel) report_mismatch("cancel", res_o, want);
          if (res_o.ghost_mode !== want.ghost_mode) report_mismatch("mode", res_o, want);
          if (res_o.ghost_count !== want.ghost_count) report_mismatch("count", res_o, want);
          if (res_o.last !== want.last) report_mismatch("last", res_o, want);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!start || took_word)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd_i <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_frame(int f, bit t, bit rep, int x, int y, int wx, int wy, int z);
    cmd_t c;
    c = '{op: OP_FRAME, finger: f[3:0], touched: t, reported: rep, pos_x: x[11:0],
          pos_y: y[11:0], width_x: wx[7:0], width_y: wy[7:0], pressure: z[7:0]};
    pending_words.push_back(c);
  endtask

  task automatic queue_op(logic [1:0] op);
    cmd_t c;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    c.op = op;
    pending_words.push_back(c);
  endtask

  task automatic wait_quiet();
    while (pending_words.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [2:0] idx, logic [15:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_setting(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one finger going down, dwelling with mostly wet-looking contact, then usually lifting
  task automatic queue_story();
    int f, x, y, n, z;
    bit rep;
    f = $urandom_range(FINGERS - 1);
    x = $urandom_range(4095);
    y = $urandom_range(4095);
    rep = $urandom_range(1);
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      z = $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(40);
      if ($urandom_range(7) == 0) begin
        x = $urandom_range(4095);
      end else begin
        x = (x + $urandom_range(20)) % 4096;
      end
      queue_frame(f, 1, rep, x, y, $urandom_range(60, 255), $urandom_range(255), z);
      if ($urandom_range(2) == 0) queue_op(OP_TICK);
      if ($urandom_range(5) == 0) rep = ~rep;
    end
    if ($urandom_range(3) != 0) queue_frame(f, 0, rep, x, y, 0, 0, 0);
    for (int i = $urandom_range(3); i > 0; i--) queue_op(OP_TICK);
  endtask

  task automatic queue_random(int target);
    int stop;
    cmd_t c;
    logic [63:0] raw;
    stop = words_in + pending_words.size() + target;
    while (words_in + pending_words.size() < stop) begin
      if ($urandom_range(4) != 0) begin
        queue_story();
      end else begin
        raw = {$urandom, $urandom};
        c = raw[$bits(cmd_t)-1:0];
        pending_words.push_back(c);
      end
    end
  endtask

  initial begin
    logic [15:0] setting [8];
    int idle_plan [5];
    idle_plan = '{0, 70, 0, 28, 70};
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    took_word = 1'b0;
    idle_pct = 0;
    cycles = 0; errors = 0; words_in = 0; words_out = 0; ghosts_seen = 0;
    reset_filter();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, with a low limit so ghosts appear quickly
    write_setting(REG_LIMIT, 16'd3);
    queue_frame(0, 1, 1, 0, 0, 255, 255, 0);
    queue_frame(0, 1, 1, 0, 0, 0, 0, 0);
    queue_frame(0, 1, 1, 1, 1, 200, 100, 10);
    queue_frame(0, 1, 1, 2, 2, 200, 100, 255);
    queue_frame(0, 1, 0, 4095, 4095, 255, 0, 255);
    queue_frame(0, 0, 0, 0, 0, 0, 0, 0);
    queue_frame(9, 1, 1, 4095, 4095, 0, 255, 1);
    queue_op(OP_TICK);
    queue_frame(9, 1, 1, 4095, 4095, 255, 255, 255);
    queue_frame(15, 1, 1, 100, 100, 1, 1, 1);
    queue_frame(10, 1, 1, 100, 100, 1, 1, 1);
    queue_op(2'd3);
    queue_op(OP_TOUCHUP);
    queue_frame(5, 1, 0, 2048, 2048, 128, 128, 10);
    queue_frame(5, 0, 0, 2048, 2048, 128, 128, 10);
    for (int i = 0; i < 35; i++) queue_op(OP_TICK);
    queue_frame(5, 1, 1, 2048, 2048, 128, 128, 10);
    wait_quiet();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: setting = '{16'd1, 16'd100, 16'd150, 16'd50, 16'd200, 16'd4, 16'd100, 16'd30};
        1: setting = '{16'd1, 16'd0, 16'd25500, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0};
        2: setting = '{16'd0, 16'd25500, 16'd0, 16'd25500, 16'd25500, 16'd255, 16'd4095,
                       16'd65535};
        3: setting = '{16'd1, 16'd25500, 16'd25500, 16'd25500, 16'd25500, 16'd6, 16'd4095,
                       16'd65535};
        default: setting = '{16'd1, 16'd1500, 16'd3000, 16'd800, 16'd5000, 16'd2, 16'd30,
                             16'd2};
      endcase
      for (int r = 0; r < 8; r++) write_setting(r[2:0], setting[r]);
      idle_pct = idle_plan[ph];
      queue_random(40);
      wait_quiet();
      idle_pct = 0;
    end

    $display("covered %0d input words and %0d result words over five filter settings",
             words_in, words_out);
    $display("ghost declarations predicted: %0d, mismatches: %0d", ghosts_seen, errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("touch_water_ghost_rejector_top regression: pass");
    end else begin
      $display("touch_water_ghost_rejector_top regression: fail");
    end
    $finish;
  end

endmodule

### touch_water_ghost_rejector_top.f
design/tgr_pkg.sv
design/tgr_div.sv
design/touch_water_ghost_rejector_top.sv
sim/touch_water_ghost_rejector_top_tb.sv
